>>> hw/rtl/ttig_pkg.sv
`timescale 1ns / 1ps

package ttig_pkg;

    // Default configuration of the generator.
    localparam int MAX_AXES_DEF   = 7;
    localparam int DIM_BITS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 32;

    // Widths fixed by the register map and the result fields.
    localparam int OUT_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PERM  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd4;

    // Register indexes (byte address is 8 times the index).
    localparam logic [1:0] REG_AXIS_COUNT = 2'd0;
    localparam logic [1:0] REG_PERM       = 2'd1;
    localparam logic [1:0] REG_DIMS_LOW   = 2'd2;
    localparam logic [1:0] REG_DIMS_HIGH  = 2'd3;

    // Register reset values.
    localparam logic [2:0]  AXIS_COUNT_RST = 3'd2;
    localparam logic [20:0] PERM_RST       = 21'd1754760;
    localparam logic [63:0] DIMS_LOW_RST   = 64'd281479271743489;
    localparam logic [47:0] DIMS_HIGH_RST  = 48'd4295032833;

    typedef struct packed {
        logic [2:0]  axis_count;
        logic [20:0] perm_packed;
        logic [63:0] out_dims_low;
        logic [47:0] out_dims_high;
    } t_cfg;

    typedef struct packed {
        logic restart;
    } t_req;

    typedef struct packed {
        logic [OUT_W-1:0]    source_index;
        logic [OUT_W-1:0]    dest_index;
        logic                last_element;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

>>> hw/rtl/ttig_front.sv
`timescale 1ns / 1ps

module ttig_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_restart,
    output logic          o_full,
    output logic          o_req_valid,
    output ttig_pkg::t_req o_req,
    input  logic          i_req_pop
);
    import ttig_pkg::*;

    // Two-entry request queue between the port and the walk engine.
    t_req       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       wr_en, rd_en;

    assign o_full      = (r_count == 2'd2);
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_mem[r_rptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_req_pop && o_req_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wptr  = r_wptr ^ wr_en;
        n_rptr  = r_rptr ^ rd_en;
        n_count = r_count + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Each beat is tagged by its restart bit for the engine.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr].restart <= i_restart;
        end
    end

endmodule

>>> hw/rtl/ttig_outq.sv
`timescale 1ns / 1ps

module ttig_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  ttig_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_empty,
    output ttig_pkg::t_result o_res,
    input  logic              i_pop
);
    import ttig_pkg::*;

    // Two-entry result queue so the engine keeps going while a beat waits.
    t_result    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       wr_en, rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_res   = r_mem[r_rptr];
    assign wr_en   = i_res_valid && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= r_wptr ^ wr_en;
            r_rptr  <= r_rptr ^ rd_en;
            r_count <= r_count + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_res;
        end
    end

endmodule

>>> hw/rtl/ttig_back.sv
`timescale 1ns / 1ps

module ttig_back #(
    parameter int MAX_AXES   = ttig_pkg::MAX_AXES_DEF,
    parameter int DIM_BITS   = ttig_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = ttig_pkg::INDEX_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttig_pkg::t_cfg    i_cfg,
    input  logic              i_cfg_wr,
    input  logic              i_req_valid,
    input  ttig_pkg::t_req    i_req,
    output logic              o_req_pop,
    input  logic              i_out_full,
    output logic              o_res_valid,
    output ttig_pkg::t_result o_res
);
    import ttig_pkg::*;

    localparam int AXW = (MAX_AXES > 2) ? $clog2(MAX_AXES) : 1;
    localparam int PW  = INDEX_BITS + DIM_BITS + 1;
    localparam logic [PW-1:0] LIMIT = PW'(1) << INDEX_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TOTAL  = 2'd1;
    localparam logic [1:0] ST_STRIDE = 2'd2;
    localparam logic [1:0] ST_TABLE  = 2'd3;

    // Unpacked view of the shape and permutation registers.
    logic [DIM_BITS-1:0] dim  [MAX_AXES];
    logic [2:0]          perm [MAX_AXES];

    genvar g;
    generate
        for (g = 0; g < MAX_AXES; g++) begin : g_unpack
            if (g < 4) begin : g_low
                assign dim[g]  = i_cfg.out_dims_low[16*g +: DIM_BITS];
                assign perm[g] = i_cfg.perm_packed[3*g +: 3];
            end else if (g < 7) begin : g_high
                assign dim[g]  = i_cfg.out_dims_high[16*(g-4) +: DIM_BITS];
                assign perm[g] = i_cfg.perm_packed[3*g +: 3];
            end else begin : g_none
                assign dim[g]  = '0;
                assign perm[g] = '0;
            end
        end
    endgenerate

    // Walk state.
    logic [1:0]            r_state, n_state;
    logic [AXW-1:0]        r_i, n_i;
    logic [AXW-1:0]        r_j, n_j;
    logic [INDEX_BITS:0]   r_total, n_total;
    logic [INDEX_BITS-1:0] r_acc, n_acc;
    logic [INDEX_BITS-1:0] r_wprod, n_wprod;
    logic [INDEX_BITS-1:0] r_src, n_src;
    logic [INDEX_BITS-1:0] r_dst, n_dst;
    logic                  r_done, n_done;
    logic [DIM_BITS-1:0]   r_pos    [MAX_AXES];
    logic [DIM_BITS-1:0]   n_pos    [MAX_AXES];
    logic [INDEX_BITS-1:0] r_stride [MAX_AXES];
    logic [INDEX_BITS-1:0] n_stride [MAX_AXES];
    logic [INDEX_BITS-1:0] r_delta  [MAX_AXES];
    logic [INDEX_BITS-1:0] n_delta  [MAX_AXES];

    // Configuration checks, made combinationally at a restart.
    logic [2:0]          n_axes;
    logic [AXW-1:0]      axis_last;
    logic                bad_count, bad_perm, is_empty, last0;
    logic [7:0]          used;
    logic [STATUS_W-1:0] chk_status;

    always_comb begin
        n_axes    = i_cfg.axis_count;
        axis_last = AXW'(n_axes - 3'd1);
        bad_count = (n_axes < 3'd2) || ({1'b0, n_axes} > 4'(MAX_AXES));
        bad_perm  = 1'b0;
        is_empty  = 1'b0;
        last0     = 1'b1;
        used      = '0;
        for (int i = 0; i < MAX_AXES; i++) begin
            if (i < int'(n_axes)) begin
                if ((perm[i] >= n_axes) || used[perm[i]]) begin
                    bad_perm = 1'b1;
                end
                used[perm[i]] = 1'b1;
                if (dim[i] == '0) begin
                    is_empty = 1'b1;
                end
                if (dim[i] != DIM_BITS'(1)) begin
                    last0 = 1'b0;
                end
            end
        end
        if (bad_count) begin
            chk_status = STATUS_BAD_COUNT;
        end else if (bad_perm) begin
            chk_status = STATUS_BAD_PERM;
        end else if (is_empty) begin
            chk_status = STATUS_EMPTY;
        end else begin
            chk_status = STATUS_OK;
        end
    end

    // Input shape: input axis j takes the size of the output axis naming it.
    logic [DIM_BITS-1:0] in_shape [MAX_AXES];

    always_comb begin
        for (int j = 0; j < MAX_AXES; j++) begin
            in_shape[j] = '0;
            for (int i = 0; i < MAX_AXES; i++) begin
                if ((i < int'(n_axes)) && (perm[i] == 3'(j))) begin
                    in_shape[j] = in_shape[j] | dim[i];
                end
            end
        end
    end

    // Source stride of the output axis under setup.
    logic [INDEX_BITS-1:0] s_sel;

    always_comb begin
        s_sel = '0;
        for (int j = 0; j < MAX_AXES; j++) begin
            if (perm[r_i] == 3'(j)) begin
                s_sel = r_stride[j];
            end
        end
    end

    // Odometer: the innermost axis that can still count up advances.
    logic [MAX_AXES-1:0]   can_inc;
    logic [AXW-1:0]        adv_k;
    logic [DIM_BITS-1:0]   adv_pos [MAX_AXES];
    logic                  adv_last;

    always_comb begin
        adv_k = '0;
        for (int i = 0; i < MAX_AXES; i++) begin
            can_inc[i] = (i < int'(n_axes)) &&
                         (({1'b0, r_pos[i]} + 1'b1) < {1'b0, dim[i]});
            if (can_inc[i]) begin
                adv_k = AXW'(i);
            end
        end
        adv_last = 1'b1;
        for (int i = 0; i < MAX_AXES; i++) begin
            if ((i < int'(n_axes)) && (AXW'(i) > adv_k)) begin
                adv_pos[i] = '0;
            end else if (AXW'(i) == adv_k) begin
                adv_pos[i] = r_pos[i] + 1'b1;
            end else begin
                adv_pos[i] = r_pos[i];
            end
            if ((i < int'(n_axes)) &&
                (({1'b0, adv_pos[i]} + 1'b1) != {1'b0, dim[i]})) begin
                adv_last = 1'b0;
            end
        end
    end

    // Sequencer: one step per cycle for advances while can_go holds, per-axis passes for setup.
    logic [PW-1:0] total_prod;
    logic          can_go;

    assign total_prod = PW'(r_total) * PW'(dim[r_i]);
    assign can_go     = i_req_valid && !i_out_full;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_total     = r_total;
        n_acc       = r_acc;
        n_wprod     = r_wprod;
        n_src       = r_src;
        n_dst       = r_dst;
        n_done      = r_done;
        n_pos       = r_pos;
        n_stride    = r_stride;
        n_delta     = r_delta;
        o_req_pop   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{source_index: '0, dest_index: '0, last_element: 1'b1,
                        status: STATUS_OK};
        unique case (r_state)
            ST_IDLE: begin
                if (can_go) begin
                    o_req_pop = 1'b1;
                    if (i_req.restart) begin
                        if (chk_status != STATUS_OK) begin
                            o_res_valid  = 1'b1;
                            o_res.status = chk_status;
                            n_done       = 1'b1;
                        end else begin
                            n_state = ST_TOTAL;
                            n_i     = '0;
                            n_total = (INDEX_BITS+1)'(1);
                        end
                    end else if (r_done) begin
                        o_res_valid = 1'b1;
                    end else begin
                        n_dst              = r_dst + 1'b1;
                        n_src              = r_src + r_delta[adv_k];
                        n_pos              = adv_pos;
                        n_done             = adv_last;
                        o_res_valid        = 1'b1;
                        o_res.source_index = OUT_W'(n_src);
                        o_res.dest_index   = OUT_W'(n_dst);
                        o_res.last_element = adv_last;
                    end
                end
            end
            ST_TOTAL: begin
                if (total_prod > LIMIT) begin
                    if (!i_out_full) begin
                        o_res_valid  = 1'b1;
                        o_res.status = STATUS_TOO_LARGE;
                        n_done       = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_total = total_prod[INDEX_BITS:0];
                    if (r_i == axis_last) begin
                        n_state             = ST_STRIDE;
                        n_j                 = axis_last;
                        n_stride[axis_last] = INDEX_BITS'(1);
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            ST_STRIDE: begin
                if (r_j == '0) begin
                    n_state = ST_TABLE;
                    n_i     = axis_last;
                    n_acc   = '0;
                    n_wprod = '0;
                end else begin
                    n_stride[r_j - 1'b1] = INDEX_BITS'(in_shape[r_j]) * r_stride[r_j];
                    n_j                  = r_j - 1'b1;
                end
            end
            ST_TABLE: begin
                // Delta folds the unwinding of all inner axes into one add.
                if (!((r_i == '0) && i_out_full)) begin
                    n_delta[r_i] = s_sel - r_acc - r_wprod;
                    n_acc        = r_acc + r_wprod;
                    n_wprod      = s_sel * INDEX_BITS'(dim[r_i] - 1'b1);
                    if (r_i == '0) begin
                        for (int i = 0; i < MAX_AXES; i++) begin
                            n_pos[i] = '0;
                        end
                        n_src              = '0;
                        n_dst              = '0;
                        n_done             = last0;
                        n_state            = ST_IDLE;
                        o_res_valid        = 1'b1;
                        o_res.last_element = last0;
                    end else begin
                        n_i = r_i - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_cfg_wr) begin
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_done  <= 1'b1;
            for (int i = 0; i < MAX_AXES; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_done  <= n_done;
            r_pos   <= n_pos;
        end
    end

    // Setup scratch and per-axis tables carry no reset.
    always_ff @(posedge i_clk) begin
        r_total  <= n_total;
        r_acc    <= n_acc;
        r_wprod  <= n_wprod;
        r_stride <= n_stride;
        r_delta  <= n_delta;
    end

    // A result beat is only offered when the result queue has room.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !i_out_full)
        else $error("result issued into a full queue");

    // Requests are taken only between setups.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_pop |-> (r_state == ST_IDLE))
        else $error("request taken during setup");

    // The element count product never collapses to zero during the check.
    a_total_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TOTAL) |-> (r_total != '0))
        else $error("element count lost during size check");

    // Setup always ends with a beat.
    a_setup_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_IDLE) && (n_state == ST_IDLE)) |-> o_res_valid)
        else $error("setup finished without a result");

endmodule

>>> hw/rtl/tensor_transpose_index_gen.sv
// Flow: a pushed advance is registered in the request queue, its beat in the result queue.
// Throughput: one advance per cycle while a request waits and the result queue has room; a
// restart with a good configuration holds the engine for a size check, a stride chain and a
// table pass. A restart rejected for its axis count, permutation or an empty size is answered
// from idle like an advance; one rejected as too large is answered from the size check.
// Reset (synchronous, active low) empties both queues, reloads the register
// defaults and leaves the walk done, awaiting a restart.
`timescale 1ns / 1ps

module tensor_transpose_index_gen #(
    parameter int MAX_AXES   = ttig_pkg::MAX_AXES_DEF,
    parameter int DIM_BITS   = ttig_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = ttig_pkg::INDEX_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ttig_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ttig_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ttig_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_restart,
    output logic                              empty,
    input  logic                              pop,
    output logic [ttig_pkg::OUT_W-1:0]        o_source_index,
    output logic [ttig_pkg::OUT_W-1:0]        o_dest_index,
    output logic                              o_last_element,
    output logic [ttig_pkg::STATUS_W-1:0]     o_status
);
    import ttig_pkg::*;

    // Configuration registers.
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_count    <= AXIS_COUNT_RST;
            r_cfg.perm_packed   <= PERM_RST;
            r_cfg.out_dims_low  <= DIMS_LOW_RST;
            r_cfg.out_dims_high <= DIMS_HIGH_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_AXIS_COUNT: r_cfg.axis_count    <= pwdata[2:0];
                REG_PERM:       r_cfg.perm_packed   <= pwdata[20:0];
                REG_DIMS_LOW:   r_cfg.out_dims_low  <= pwdata;
                REG_DIMS_HIGH:  r_cfg.out_dims_high <= pwdata[47:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            REG_AXIS_COUNT: prdata = APB_DATA_W'(r_cfg.axis_count);
            REG_PERM:       prdata = APB_DATA_W'(r_cfg.perm_packed);
            REG_DIMS_LOW:   prdata = r_cfg.out_dims_low;
            REG_DIMS_HIGH:  prdata = APB_DATA_W'(r_cfg.out_dims_high);
            default:        prdata = '0;
        endcase
    end

    // Front request queue, walk engine, result queue.
    t_req    req;
    logic    req_valid, req_pop;
    t_result eng_res, out_res;
    logic    eng_valid, out_full;

    ttig_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_restart   (i_restart),
        .o_full      (full),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    ttig_back #(
        .MAX_AXES   (MAX_AXES),
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_wr    (cfg_wr),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_pop   (req_pop),
        .i_out_full  (out_full),
        .o_res_valid (eng_valid),
        .o_res       (eng_res)
    );

    ttig_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (eng_valid),
        .i_res       (eng_res),
        .o_full      (out_full),
        .o_empty     (empty),
        .o_res       (out_res),
        .i_pop       (pop)
    );

    assign o_source_index = out_res.source_index;
    assign o_dest_index   = out_res.dest_index;
    assign o_last_element = out_res.last_element;
    assign o_status       = out_res.status;

endmodule
